FILE: sv/turtle_statement_splitter_top_defines.svh
// ----------------------------------------------------------------------------
// Turtle statement splitter assertion macros
// Shared macros for the concurrent checks of the splitter.
// ----------------------------------------------------------------------------
`ifndef TURTLE_STATEMENT_SPLITTER_TOP_DEFINES_SVH
`define TURTLE_STATEMENT_SPLITTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TSS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TSS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/tss_pkg.sv
// ----------------------------------------------------------------------------
// Turtle statement splitter package
// Scan modes, character codes and the control and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

   typedef enum logic [2:0] {
      MODE_FREE    = 3'd0,
      MODE_ANGLES  = 3'd1,
      MODE_QUOTES  = 3'd2,
      MODE_LONG    = 3'd3,
      MODE_COMMENT = 3'd4,
      MODE_Q1      = 3'd5,
      MODE_Q2      = 3'd6
   } mode_type;

   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] WS_MIN    = 8'd1;
   localparam logic [7:0] WS_MAX    = 8'd32;

   localparam int unsigned      COUNT_W     = 16;
   localparam logic [COUNT_W-1:0] SPC_RESET = 16'd1000;

   // What the scanner does with the byte of the accepted item.
   typedef struct packed {
      logic scan;   // byte belongs to a statement
      logic skip;   // leading whitespace, only the backslash run breaks
      logic clear;  // flush item
   } scan_ctl_type;

   typedef struct packed {
      logic in_statement;
      logic stmt_end;
      logic is_directive;
      logic chunk_end;
      logic partial_dropped;
   } result_type;

endpackage

`default_nettype wire

FILE: sv/tss_scanner.sv
// ----------------------------------------------------------------------------
// Turtle lexical scanner
// Tracks IRIs, strings, long strings, comments and backslash escapes, and
// flags the period that ends a statement.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_scanner (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tss_pkg::scan_ctl_type ctl,
   input  wire logic [7:0]            byte_in,
   output      logic                  stmt_end,
   output      tss_pkg::mode_type     mode
);

   tss_pkg::mode_type mode_ff, mode_in;
   logic              bs_ff, bs_in;
   logic [1:0]        run_ff, run_in;
   logic              is_quote;
   logic              free_like;

   assign is_quote = (byte_in == tss_pkg::CH_QUOTE) && !bs_ff;
   assign mode     = mode_ff;

   // Next state of the scan.
   always_comb begin
      mode_in = mode_ff;
      run_in  = run_ff;
      bs_in   = bs_ff;
      if (ctl.clear) begin
         mode_in = tss_pkg::MODE_FREE;
         run_in  = 2'd0;
         bs_in   = 1'b0;
      end else if (ctl.skip) begin
         bs_in = 1'b0;
      end else if (ctl.scan) begin
         bs_in = (byte_in == tss_pkg::CH_BSLASH) ? !bs_ff : 1'b0;
         unique case (mode_ff)
            tss_pkg::MODE_ANGLES: begin
               if (byte_in == tss_pkg::CH_GT) mode_in = tss_pkg::MODE_FREE;
            end
            tss_pkg::MODE_QUOTES: begin
               if (is_quote) mode_in = tss_pkg::MODE_FREE;
            end
            tss_pkg::MODE_LONG: begin
               if (is_quote) begin
                  if (run_ff == 2'd2) begin
                     mode_in = tss_pkg::MODE_FREE;
                     run_in  = 2'd0;
                  end else begin
                     run_in = run_ff + 2'd1;
                  end
               end else begin
                  run_in = 2'd0;
               end
            end
            tss_pkg::MODE_COMMENT: begin
               if (byte_in == tss_pkg::CH_NL) mode_in = tss_pkg::MODE_FREE;
            end
            tss_pkg::MODE_Q1: begin
               mode_in = (byte_in == tss_pkg::CH_QUOTE) ? tss_pkg::MODE_Q2
                                                        : tss_pkg::MODE_QUOTES;
            end
            tss_pkg::MODE_Q2: begin
               if (byte_in == tss_pkg::CH_QUOTE) begin
                  mode_in = tss_pkg::MODE_LONG;
                  run_in  = 2'd0;
               end else begin
                  mode_in = tss_pkg::MODE_FREE;
                  if (byte_in == tss_pkg::CH_LT) mode_in = tss_pkg::MODE_ANGLES;
                  else if (is_quote) mode_in = tss_pkg::MODE_Q1;
                  else if (byte_in == tss_pkg::CH_HASH) mode_in = tss_pkg::MODE_COMMENT;
               end
            end
            default: begin
               // Free mode, and the unused code, which behaves as free.
               mode_in = tss_pkg::MODE_FREE;
               if (byte_in == tss_pkg::CH_LT) mode_in = tss_pkg::MODE_ANGLES;
               else if (is_quote) mode_in = tss_pkg::MODE_Q1;
               else if (byte_in == tss_pkg::CH_HASH) mode_in = tss_pkg::MODE_COMMENT;
            end
         endcase
      end
   end

   // A period only ends a statement where the byte is scanned as free text.
   always_comb begin
      unique case (mode_ff)
         tss_pkg::MODE_ANGLES, tss_pkg::MODE_QUOTES, tss_pkg::MODE_LONG,
         tss_pkg::MODE_COMMENT, tss_pkg::MODE_Q1: free_like = 1'b0;
         default:                                  free_like = 1'b1;
      endcase
      stmt_end = ctl.scan && free_like && (byte_in == tss_pkg::CH_DOT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= tss_pkg::MODE_FREE;
         run_ff  <= 2'd0;
         bs_ff   <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         run_ff  <= run_in;
         bs_ff   <= bs_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/tss_tracker.sv
// ----------------------------------------------------------------------------
// Turtle statement and chunk tracker
// Finds statement starts, directives and chunk boundaries, and forms the
// tags of each item.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_tracker (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            byte_in,
   input  wire logic                  flush,
   input  wire logic                  csr_wr_en,
   input  wire logic [15:0]           csr_wr_data,
   input  wire logic                  stmt_end,
   output      tss_pkg::scan_ctl_type ctl,
   output      tss_pkg::result_type   result,
   output      logic                  at_start
);

   logic [tss_pkg::COUNT_W-1:0] spc_ff;
   logic [tss_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [tss_pkg::COUNT_W-1:0] count_inc;
   logic                        start_ff, start_in;
   logic                        dir_ff, dir_in;
   logic                        open_ff, open_in;
   logic                        is_ws;
   logic                        dir_cur;
   logic                        close;

   assign is_ws   = (byte_in >= tss_pkg::WS_MIN) && (byte_in <= tss_pkg::WS_MAX);
   assign dir_cur = start_ff ? (byte_in == tss_pkg::CH_AT) : dir_ff;
   assign at_start = start_ff;

   assign ctl.clear = accept && flush;
   assign ctl.skip  = accept && !flush && start_ff && is_ws;
   assign ctl.scan  = accept && !flush && !(start_ff && is_ws);

   // Directives are not counted, but a lowered limit still closes on them.
   assign count_inc = dir_cur ? count_ff
                              : count_ff + {{(tss_pkg::COUNT_W-1){1'b0}}, 1'b1};
   assign close     = stmt_end && (count_inc >= spc_ff);

   always_comb begin
      count_in = count_ff;
      start_in = start_ff;
      dir_in   = dir_ff;
      open_in  = open_ff;
      if (ctl.clear) begin
         count_in = '0;
         start_in = 1'b1;
         dir_in   = 1'b0;
         open_in  = 1'b0;
      end else if (ctl.scan) begin
         start_in = 1'b0;
         dir_in   = dir_cur;
         if (stmt_end) begin
            start_in = 1'b1;
            open_in  = !close;
            count_in = close ? '0 : count_inc;
         end
      end
   end

   always_comb begin
      result.in_statement    = ctl.scan;
      result.stmt_end        = stmt_end;
      result.is_directive    = ctl.scan && dir_cur;
      result.chunk_end       = flush ? open_ff : close;
      result.partial_dropped = flush && !start_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spc_ff   <= tss_pkg::SPC_RESET;
         count_ff <= '0;
         start_ff <= 1'b1;
         dir_ff   <= 1'b0;
         open_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) spc_ff <= csr_wr_data;
         count_ff <= count_in;
         start_ff <= start_in;
         dir_ff   <= dir_in;
         open_ff  <= open_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/turtle_statement_splitter_top.sv
// ----------------------------------------------------------------------------
// Turtle statement splitter
// Tags each byte of a Turtle text stream with statement and chunk marks.
// ----------------------------------------------------------------------------
// One byte enters per item and leaves in the next cycle with its tags; the
// block takes an item in every cycle unless stalled, since the scanner and
// the statement tracker update their state within the cycle in which the
// item is accepted and the tags go into a single output register. A stall
// on the result side holds the input side only while that register is full
// and not taken. An item with req_tlast set is a flush: it resets the scan,
// closes an open chunk and reports an unfinished statement as dropped.
`default_nettype none

`include "turtle_statement_splitter_top_defines.svh"

module turtle_statement_splitter_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic        req_tlast,   // flush
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output      logic [3:0]  rsp_tuser,   // [0] in_statement, [1] stmt_end,
                                         // [2] is_directive, [3] partial_dropped
   output      logic        rsp_tlast,   // chunk_end
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   tss_pkg::scan_ctl_type ctl;
   tss_pkg::result_type   result;
   tss_pkg::mode_type     mode;
   logic                  accept;
   logic                  stmt_end;
   logic                  at_start;
   logic                  valid_ff, valid_in;
   logic [7:0]            data_ff;
   logic [3:0]            user_ff;
   logic                  last_ff;

   assign req_tready = !valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign valid_in   = accept || (valid_ff && !rsp_tready);

   tss_scanner u_scanner (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .byte_in  (req_tdata),
      .stmt_end (stmt_end),
      .mode     (mode)
   );

   tss_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .byte_in     (req_tdata),
      .flush       (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .stmt_end    (stmt_end),
      .ctl         (ctl),
      .result      (result),
      .at_start    (at_start)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_tlast ? 8'd0 : req_tdata;
         user_ff <= {result.partial_dropped, result.is_directive,
                     result.stmt_end, result.in_statement};
         last_ff <= result.chunk_end;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

   `TSS_ASSERT_NXT(a_flush_clears_scan, clock, reset, accept && req_tlast,
      mode == tss_pkg::MODE_FREE && at_start, "flush left scan state behind")
   `TSS_ASSERT_NXT(a_accept_gives_result, clock, reset, accept,
      rsp_tvalid, "accepted item produced no result")
   `TSS_ASSERT_IMP(a_no_overwrite, clock, reset, accept,
      !(valid_ff && !rsp_tready), "result register overwritten while held")
   `TSS_ASSERT_IMP(a_end_in_statement, clock, reset, rsp_tvalid && rsp_tuser[1],
      rsp_tuser[0] && rsp_tdata == tss_pkg::CH_DOT, "statement end not on a period")

endmodule

`default_nettype wire
